// File: rtl/core/hsvch_pkg.sv
// Shared types, constants and the pixel classifier for the HSV color histogram.
package hsvch_pkg;

    localparam int unsigned MAX_PIXELS  = 1048576;
    localparam int unsigned CNT_W       = $clog2(MAX_PIXELS + 1);
    localparam int unsigned NUM_CLASSES = 11;
    localparam int unsigned CLS_W       = 4;
    localparam int unsigned PCT_W       = 7;
    localparam int unsigned BIT_W       = 3;
    localparam int unsigned NUM_W       = CNT_W + PCT_W;

    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_PIXELS);
    localparam logic [BIT_W-1:0] TOP_BIT   = BIT_W'(PCT_W - 1);
    localparam logic [CLS_W-1:0] LAST_CLS  = CLS_W'(NUM_CLASSES - 1);

    // classification thresholds
    localparam logic [7:0] V_BLACK      = 8'd75;
    localparam logic [7:0] V_WHITE      = 8'd190;
    localparam logic [7:0] S_WHITE      = 8'd27;
    localparam logic [7:0] S_GREY       = 8'd53;
    localparam logic [7:0] V_GREY       = 8'd185;
    localparam logic [7:0] H_RED        = 8'd14;
    localparam logic [7:0] H_ORANGE     = 8'd25;
    localparam logic [7:0] H_YELLOW     = 8'd34;
    localparam logic [7:0] H_GREEN      = 8'd73;
    localparam logic [7:0] H_AQUA       = 8'd102;
    localparam logic [7:0] H_BLUE       = 8'd127;
    localparam logic [7:0] H_PURPLE     = 8'd149;
    localparam logic [7:0] H_PINK       = 8'd175;

    typedef enum logic [CLS_W-1:0] {
        CLS_BLACK  = 4'd0,
        CLS_WHITE  = 4'd1,
        CLS_GREY   = 4'd2,
        CLS_RED    = 4'd3,
        CLS_ORANGE = 4'd4,
        CLS_YELLOW = 4'd5,
        CLS_GREEN  = 4'd6,
        CLS_AQUA   = 4'd7,
        CLS_BLUE   = 4'd8,
        CLS_PURPLE = 4'd9,
        CLS_PINK   = 4'd10
    } t_class;

    typedef struct packed {
        logic             accum;
        logic             scan;
        logic             scan_first;
        logic             load;
        logic             div_step;
        logic             clear;
        logic [CLS_W-1:0] sel;
        logic [BIT_W-1:0] bit_idx;
    } t_cmd;

    function automatic t_class classify(input logic [7:0] h, input logic [7:0] s,
                                        input logic [7:0] v);
        t_class c;
        if (v < V_BLACK)                  c = CLS_BLACK;
        else if (v > V_WHITE && s < S_WHITE) c = CLS_WHITE;
        else if (s < S_GREY && v < V_GREY)   c = CLS_GREY;
        else if (h < H_RED)               c = CLS_RED;
        else if (h < H_ORANGE)            c = CLS_ORANGE;
        else if (h < H_YELLOW)            c = CLS_YELLOW;
        else if (h < H_GREEN)             c = CLS_GREEN;
        else if (h < H_AQUA)              c = CLS_AQUA;
        else if (h < H_BLUE)              c = CLS_BLUE;
        else if (h < H_PURPLE)            c = CLS_PURPLE;
        else if (h < H_PINK)              c = CLS_PINK;
        else                              c = CLS_RED;
        return c;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (x < CNT_MAX) ? x + 1'b1 : CNT_MAX;
    endfunction

endpackage

// File: rtl/core/hsvch_if.sv
// Valid/ready channel interfaces for pixel words and histogram result words.
interface hsvch_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic       region_end;

    modport source (output valid, hue, saturation, brightness, region_end, input ready);
    modport sink   (input valid, hue, saturation, brightness, region_end, output ready);
endinterface

interface hsvch_res_if;
    logic                          valid;
    logic                          ready;
    logic [hsvch_pkg::CLS_W-1:0]   color_class;
    logic [hsvch_pkg::PCT_W-1:0]   percent;
    logic [hsvch_pkg::CLS_W-1:0]   dominant_class;
    logic                          last_of_run;

    modport source (output valid, color_class, percent, dominant_class, last_of_run,
                    input ready);
    modport sink   (input valid, color_class, percent, dominant_class, last_of_run,
                    output ready);
endinterface

// File: rtl/core/hsvch_ctrl.sv
// Sequencer: pixel accumulation, dominant scan, per-class division and result hand-off.
module hsvch_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hsvch_pkg::t_cmd   o_cmd
);

    typedef enum logic [4:0] {
        ST_ACCUM = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state                       r_state, n_state;
    logic [hsvch_pkg::CLS_W-1:0]  r_cls,   n_cls;
    logic [hsvch_pkg::BIT_W-1:0]  r_bit,   n_bit;

    always_comb begin
        n_state     = r_state;
        n_cls       = r_cls;
        n_bit       = r_bit;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        o_cmd.sel     = r_cls;
        o_cmd.bit_idx = r_bit;
        unique case (r_state)
            ST_ACCUM: begin
                o_in_ready  = 1'b1;
                o_cmd.accum = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = ST_SCAN;
                    n_cls   = '0;
                end
            end
            ST_SCAN: begin
                o_cmd.scan       = 1'b1;
                o_cmd.scan_first = (r_cls == '0);
                if (r_cls == hsvch_pkg::LAST_CLS) begin
                    n_state = ST_LOAD;
                    n_cls   = '0;
                end else begin
                    n_cls = r_cls + 1'b1;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_bit      = hsvch_pkg::TOP_BIT;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_bit == '0) n_state = ST_EMIT;
                else             n_bit   = r_bit - 1'b1;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_cls == hsvch_pkg::LAST_CLS) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_ACCUM;
                    end else begin
                        n_cls   = r_cls + 1'b1;
                        n_state = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_ACCUM;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
            r_cls   <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_cls   <= n_cls;
            r_bit   <= n_bit;
        end
    end

endmodule

// File: rtl/core/hsvch_datapath.sv
// Tallies, pixel count, dominant-class search and the bit-serial percent divider.
module hsvch_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hsvch_pkg::t_cmd              i_cmd,
    input  logic [7:0]                   i_hue,
    input  logic [7:0]                   i_saturation,
    input  logic [7:0]                   i_brightness,
    output logic [hsvch_pkg::CLS_W-1:0]  o_color_class,
    output logic [hsvch_pkg::PCT_W-1:0]  o_percent,
    output logic [hsvch_pkg::CLS_W-1:0]  o_dominant_class,
    output logic                         o_last_of_run
);

    localparam int unsigned CW = hsvch_pkg::CNT_W;
    localparam int unsigned NW = hsvch_pkg::NUM_W;

    logic [CW-1:0]                 r_tally [hsvch_pkg::NUM_CLASSES];
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 r_best;
    logic [hsvch_pkg::CLS_W-1:0]   r_dom;
    logic [NW-1:0]                 r_rem;
    logic [hsvch_pkg::PCT_W-1:0]   r_quo;

    hsvch_pkg::t_class             pix_cls;
    logic [CW-1:0]                 tally_sel;
    logic [NW-1:0]                 tally_x100;
    logic [NW-1:0]                 div_shift;
    logic                          div_ge;

    assign pix_cls   = hsvch_pkg::classify(i_hue, i_saturation, i_brightness);
    assign tally_sel = r_tally[i_cmd.sel];

    // x*100 = x*64 + x*32 + x*4
    assign tally_x100 = (NW'(tally_sel) << 6) + (NW'(tally_sel) << 5) + (NW'(tally_sel) << 2);
    assign div_shift  = NW'(r_count) << i_cmd.bit_idx;
    assign div_ge     = (r_rem >= div_shift);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < hsvch_pkg::NUM_CLASSES; j++) r_tally[j] <= '0;
            r_count <= '0;
        end else if (i_cmd.clear) begin
            for (int j = 0; j < hsvch_pkg::NUM_CLASSES; j++) r_tally[j] <= '0;
            r_count <= '0;
        end else if (i_cmd.accum) begin
            for (int j = 0; j < hsvch_pkg::NUM_CLASSES; j++) begin
                if (pix_cls == hsvch_pkg::CLS_W'(j))
                    r_tally[j] <= hsvch_pkg::sat_inc(r_tally[j]);
            end
            r_count <= hsvch_pkg::sat_inc(r_count);
        end
    end

    // first maximum wins: strict compare after the first class
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && (i_cmd.scan_first || tally_sel > r_best)) begin
            r_best <= tally_sel;
            r_dom  <= i_cmd.sel;
        end
    end

    // restoring division, one quotient bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= tally_x100;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            if (div_ge) r_rem <= r_rem - div_shift;
            r_quo <= {r_quo[hsvch_pkg::PCT_W-2:0], div_ge};
        end
    end

    assign o_color_class    = i_cmd.sel;
    assign o_percent        = r_quo;
    assign o_dominant_class = r_dom;
    assign o_last_of_run    = (i_cmd.sel == hsvch_pkg::LAST_CLS);

endmodule

// File: rtl/core/hsv_color_class_histogram.sv
// Top level of the HSV color-class histogram: sequencer plus datapath.
// Usage:
//   i_pix takes one HSV pixel word per cycle while ready is high; region_end
//   marks the last pixel of a region. Each pixel is classified into one of
//   eleven color classes and counted in the cycle it is accepted.
//   After the flagged pixel, i_pix.ready drops and the block finds the
//   dominant class (one tally compared per cycle), then for each
//   class computes tally*100/count with a restoring divider: a load step,
//   then one quotient bit per divide step, MSB first, then holds the word on o_res.
//   Eleven result words leave in class order, the last with last_of_run set.
//   Pixels are taken again only after the eleventh word has left; a stalled
//   receiver simply holds the result word and the sequencer waits.
//   Tallies and count clear after the eleventh word.
//   Reset (synchronous, i_rst_n low) clears tallies, count and the sequencer;
//   the block then accepts pixels at once.
module hsv_color_class_histogram (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hsvch_pix_if.sink    i_pix,
    hsvch_res_if.source  o_res
);

    hsvch_pkg::t_cmd cmd;

    hsvch_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_in_last   (i_pix.region_end),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd)
    );

    hsvch_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_hue            (i_pix.hue),
        .i_saturation     (i_pix.saturation),
        .i_brightness     (i_pix.brightness),
        .o_color_class    (o_res.color_class),
        .o_percent        (o_res.percent),
        .o_dominant_class (o_res.dominant_class),
        .o_last_of_run    (o_res.last_of_run)
    );

endmodule

// File: sim/tb_top.sv
// Testbench for the HSV color-class histogram: directed table plus random regions, self-checked.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [hsvch_pkg::CLS_W-1:0] cls;
        logic [hsvch_pkg::PCT_W-1:0] pct;
        logic [hsvch_pkg::CLS_W-1:0] dom;
        logic                        last;
    } t_res_word;

    typedef struct {
        logic [7:0]        h;
        logic [7:0]        s;
        logic [7:0]        v;
        logic              end_f;
        int                reps;
        bit                typed;
        hsvch_pkg::t_class exp_cls;
    } t_stim_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    localparam int N_DIRECTED  = 23;
    localparam int N_RANDOM    = 200;
    localparam int HOLD_CYCLES = 500;

    // typed rows are one-class regions: that class gets 100 and dominates
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{8'd0,   8'd0,   8'd74,  1'b1, 1, 1'b1, hsvch_pkg::CLS_BLACK},
        '{8'd255, 8'd26,  8'd191, 1'b1, 1, 1'b1, hsvch_pkg::CLS_WHITE},
        '{8'd100, 8'd52,  8'd184, 1'b1, 1, 1'b1, hsvch_pkg::CLS_GREY},
        '{8'd255, 8'd255, 8'd255, 1'b1, 1, 1'b1, hsvch_pkg::CLS_RED},
        // one region walking every threshold; hue ones from both sides save H_RED, the rest with the typed rows above
        '{8'd0,   8'd0,   8'd75,  1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd0,   8'd0,   8'd190, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd14,  8'd27,  8'd191, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd24,  8'd53,  8'd185, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd25,  8'd255, 8'd255, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd33,  8'd255, 8'd255, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd34,  8'd255, 8'd255, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd72,  8'd255, 8'd255, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd73,  8'd255, 8'd255, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd101, 8'd255, 8'd255, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd102, 8'd255, 8'd255, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd126, 8'd255, 8'd255, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd127, 8'd255, 8'd255, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd148, 8'd255, 8'd255, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd149, 8'd255, 8'd255, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd174, 8'd255, 8'd255, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd175, 8'd255, 8'd255, 1'b1, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        // tie between blue and green: lower index wins
        '{8'd110, 8'd255, 8'd255, 1'b0, 1, 1'b0, hsvch_pkg::CLS_BLACK},
        '{8'd50,  8'd255, 8'd255, 1'b1, 1, 1'b0, hsvch_pkg::CLS_BLACK}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hsvch_pix_if pix_ch ();
    hsvch_res_if res_ch ();

    hsv_color_class_histogram i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // histogram predictor state
    logic [hsvch_pkg::CNT_W-1:0] class_count [hsvch_pkg::NUM_CLASSES];
    logic [hsvch_pkg::CNT_W-1:0] region_pixels;
    t_res_word                   closing_words [hsvch_pkg::NUM_CLASSES];
    t_res_word                   expected_words [$];

    int          mismatches   = 0;
    int          burst_left   = 0;
    int          random_taken = 0;
    bit          hold_active  = 1'b0;
    t_stall_mode stall_mode   = STALL_NONE;
    int          stall_left   = 0;

    function automatic hsvch_pkg::t_class pixel_class(input logic [7:0] h,
                                                      input logic [7:0] s,
                                                      input logic [7:0] v);
        if (v < hsvch_pkg::V_BLACK) return hsvch_pkg::CLS_BLACK;
        if (v > hsvch_pkg::V_WHITE && s < hsvch_pkg::S_WHITE) return hsvch_pkg::CLS_WHITE;
        if (s < hsvch_pkg::S_GREY && v < hsvch_pkg::V_GREY)   return hsvch_pkg::CLS_GREY;
        // hue bands from the top down; the top band wraps back to red
        if (h >= hsvch_pkg::H_PINK)   return hsvch_pkg::CLS_RED;
        if (h >= hsvch_pkg::H_PURPLE) return hsvch_pkg::CLS_PINK;
        if (h >= hsvch_pkg::H_BLUE)   return hsvch_pkg::CLS_PURPLE;
        if (h >= hsvch_pkg::H_AQUA)   return hsvch_pkg::CLS_BLUE;
        if (h >= hsvch_pkg::H_GREEN)  return hsvch_pkg::CLS_AQUA;
        if (h >= hsvch_pkg::H_YELLOW) return hsvch_pkg::CLS_GREEN;
        if (h >= hsvch_pkg::H_ORANGE) return hsvch_pkg::CLS_YELLOW;
        if (h >= hsvch_pkg::H_RED)    return hsvch_pkg::CLS_ORANGE;
        return hsvch_pkg::CLS_RED;
    endfunction

    function automatic logic [hsvch_pkg::CNT_W-1:0] bump(
        input logic [hsvch_pkg::CNT_W-1:0] x);
        return (x >= hsvch_pkg::CNT_MAX) ? hsvch_pkg::CNT_MAX : x + 1'b1;
    endfunction

    // Counts one pixel; on a region end fills closing_words and clears the histogram.
    function automatic bit tally_pixel(input logic [7:0] h, input logic [7:0] s,
                                       input logic [7:0] v, input logic end_f);
        hsvch_pkg::t_class           c;
        logic [hsvch_pkg::CLS_W-1:0] lead;
        longint unsigned             share;
        c = pixel_class(h, s, v);
        class_count[c] = bump(class_count[c]);
        region_pixels  = bump(region_pixels);
        if (!end_f) return 1'b0;
        lead = '0;
        for (int k = 1; k < hsvch_pkg::NUM_CLASSES; k++)
            if (class_count[k] > class_count[lead]) lead = hsvch_pkg::CLS_W'(k);
        for (int k = 0; k < hsvch_pkg::NUM_CLASSES; k++) begin
            share = (longint'(class_count[k]) * 100) / longint'(region_pixels);
            closing_words[k] = '{hsvch_pkg::CLS_W'(k), hsvch_pkg::PCT_W'(share), lead,
                                 k == hsvch_pkg::NUM_CLASSES - 1};
        end
        foreach (class_count[k]) class_count[k] = '0;
        region_pixels = '0;
        return 1'b1;
    endfunction

    task automatic send_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v,
                              input logic end_f, input bit may_idle, input bit typed,
                              input hsvch_pkg::t_class exp_cls);
        if (may_idle) begin
            if (burst_left == 0) begin
                pix_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 10);
            end
            burst_left--;
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.hue        <= h;
        pix_ch.saturation <= s;
        pix_ch.brightness <= v;
        pix_ch.region_end <= end_f;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        if (tally_pixel(h, s, v, end_f)) begin
            for (int k = 0; k < hsvch_pkg::NUM_CLASSES; k++)
                expected_words.push_back(typed
                    ? t_res_word'{hsvch_pkg::CLS_W'(k),
                                  (k == exp_cls) ? hsvch_pkg::PCT_W'(100) : '0,
                                  exp_cls, k == hsvch_pkg::NUM_CLASSES - 1}
                    : closing_words[k]);
        end
    endtask

    task automatic flag_mismatch(input string what, input t_res_word want,
                                 input t_res_word got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t mismatch (%s): exp cls=%0d pct=%0d dom=%0d last=%0d,",
                      " got cls=%0d pct=%0d dom=%0d last=%0d"},
                     $realtime, what, want.cls, want.pct, want.dom, want.last,
                     got.cls, got.pct, got.dom, got.last);
    endtask

    always @(posedge i_clk) begin : result_check
        t_res_word want;
        t_res_word got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.color_class, res_ch.percent, res_ch.dominant_class,
                    res_ch.last_of_run};
            if (expected_words.size() == 0) begin
                flag_mismatch("no word expected", '0, got);
            end else begin
                want = expected_words.pop_front();
                if (got.cls !== want.cls || got.pct !== want.pct ||
                    got.dom !== want.dom || got.last !== want.last)
                    flag_mismatch("wrong field", want, got);
            end
        end
    end

    // receiver: ready follows a stall pattern picked at random, held low during the hold-off
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:   res_ch.ready <= !hold_active;
            STALL_LIGHT:  res_ch.ready <= !hold_active && ($urandom_range(0, 3) != 0);
            STALL_HEAVY:  res_ch.ready <= !hold_active && ($urandom_range(0, 1) != 0);
            STALL_TOGGLE: res_ch.ready <= !hold_active && !res_ch.ready;
            default:      res_ch.ready <= !hold_active;
        endcase
    end

    // long hold-off on results while pixels keep coming, so the input backs up
    initial begin
        wait (random_taken >= 60);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int         region_len;
        logic [7:0] th, ts, tv, h, s, v;
        pix_ch.valid      = 1'b0;
        pix_ch.hue        = '0;
        pix_ch.saturation = '0;
        pix_ch.brightness = '0;
        pix_ch.region_end = 1'b0;
        res_ch.ready      = 1'b0;
        foreach (class_count[k]) class_count[k] = '0;
        region_pixels = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            for (int r = 0; r < directed_rows[i].reps; r++)
                send_pixel(directed_rows[i].h, directed_rows[i].s, directed_rows[i].v,
                           directed_rows[i].end_f && (r == directed_rows[i].reps - 1),
                           directed_rows[i].reps == 1, directed_rows[i].typed,
                           directed_rows[i].exp_cls);
        end

        // random regions: half the pixels repeat a per-region color so dominance varies
        while (random_taken < N_RANDOM) begin
            region_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 60)
                                                     : $urandom_range(1, 16);
            th = ($urandom_range(0, 3) == 0) ? $urandom_range(180, 255) : $urandom_range(0, 179);
            ts = $urandom_range(0, 255);
            tv = $urandom_range(0, 255);
            for (int i = 0; i < region_len; i++) begin
                if ($urandom_range(0, 1) != 0) begin
                    h = th;
                    s = ts;
                    v = tv;
                end else begin
                    h = ($urandom_range(0, 3) == 0) ? $urandom_range(180, 255)
                                                    : $urandom_range(0, 179);
                    s = $urandom_range(0, 255);
                    v = $urandom_range(0, 255);
                end
                send_pixel(h, s, v, i == region_len - 1, 1'b1, 1'b0, hsvch_pkg::CLS_BLACK);
                random_taken++;
            end
        end
        pix_ch.valid <= 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/hsvch_pkg.sv
rtl/core/hsvch_if.sv
rtl/core/hsvch_ctrl.sv
rtl/core/hsvch_datapath.sv
rtl/core/hsv_color_class_histogram.sv
sim/tb_top.sv
